[design/ffs_pkg.sv]
// ----------------------------------------------------------------------------
// ffs_pkg
// Shared types and constants of the flag frame splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffs_pkg;

  // window depth and length of the skipped leading flag
  localparam int unsigned FLAG_BITS = 8;
  localparam int unsigned PAT_W     = 8;
  localparam int unsigned SKIP_W    = $clog2(FLAG_BITS + 1);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PAT_W-1:0] FLAG_PATTERN_RST = 8'b0111_1110;

  localparam logic [CFG_IDX_W-1:0] REG_FLAG_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_FLAG    = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_BOUNDARY = 2'd1,
    KIND_END      = 2'd2
  } kind_e;

  typedef struct packed {
    logic bit_in;
    logic message_end;
  } ffs_in_t;

  typedef struct packed {
    kind_e kind;
    logic  bit_out;
    logic  last;
  } ffs_out_t;

  // per-cycle control of one window cell
  typedef struct packed {
    logic shift;
    logic kill;
    logic pop;
  } ffs_cell_ctl_t;

  // pattern limited or zero-extended to the window depth
  function automatic logic [FLAG_BITS-1:0] flag_window(input logic [PAT_W-1:0] pat);
    logic [FLAG_BITS+PAT_W-1:0] ext;
    begin
      ext = {{FLAG_BITS{1'b0}}, pat};
      return ext[FLAG_BITS-1:0];
    end
  endfunction

endpackage

[design/ffs_cell.sv]
// ----------------------------------------------------------------------------
// ffs_cell
// One bit of the lookahead window: takes the bit of its younger neighbor
// on a shift and reports whether it holds the oldest pending bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffs_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ffs_pkg::ffs_cell_ctl_t ctl_i,
  input  logic                   prev_bit_i,
  input  logic                   prev_valid_i,
  input  logic                   above_valid_i,
  output logic                   valid_o,
  output logic                   bit_o,
  output logic                   sh_bit_o,
  output logic                   sh_valid_o,
  output logic                   head_o
);
  import ffs_pkg::*;

  logic bit_q, bit_d;
  logic valid_q, valid_d;

  // value after an optional shift, used for the flag compare
  assign sh_bit_o   = ctl_i.shift ? prev_bit_i   : bit_q;
  assign sh_valid_o = ctl_i.shift ? prev_valid_i : valid_q;
  assign head_o     = valid_q & ~above_valid_i;
  assign valid_o    = valid_q;
  assign bit_o      = bit_q;

  always_comb begin
    bit_d   = sh_bit_o;
    valid_d = sh_valid_o;
    if (ctl_i.kill || (ctl_i.pop && head_o)) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

endmodule

[design/ffs_out_buf.sv]
// ----------------------------------------------------------------------------
// ffs_out_buf
// Output register with a skid entry, so a new result can be taken while the
// receiver stalls the current one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffs_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ffs_pkg::ffs_out_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ffs_pkg::ffs_out_t out_data_o
);
  import ffs_pkg::*;

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  ffs_out_t out_q, out_d;
  ffs_out_t skid_q, skid_d;
  logic     pop;

  assign pop         = out_valid_q & ~out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

[design/flag_frame_splitter_unit.sv]
// ----------------------------------------------------------------------------
// flag_frame_splitter_unit
// Splits a serial bit stream into frames at a flag pattern.
// ----------------------------------------------------------------------------
// Input channel: one stream bit per transfer with a message_end mark.
// Output channel: one result per transfer (data bit, frame boundary or end
// of message), last set on the final result caused by an input bit.
// Config channel: always ready; index 0 is the flag pattern (oldest bit in
// the msb), index 1 enables dropping of the first eight bits of a message.
// The window is a row of cells; each input bit that is not skipped shifts
// it by one, and a full window is matched against the pattern in the same
// cycle. A result is registered in the output buffer, or in its skid entry
// while the receiver stalls, and is shown on out_valid_o from there.
// Throughput: one input bit per cycle while the input is not stalled. After
// a bit marked message_end the input stalls while pending bits and the end
// marker leave through the single output port, one per cycle while the skid
// entry is free. A receiver stall is absorbed by a skid entry; input stalls
// when that entry is occupied or while that flush runs.
// Reset: pattern 01111110, leading flag drop on, window empty, no results
// pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flag_frame_splitter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ffs_pkg::ffs_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ffs_pkg::ffs_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ffs_pkg::PAT_W-1:0]        cfg_data_i
);
  import ffs_pkg::*;

  logic [PAT_W-1:0]  flag_pattern_q;
  logic              skip_flag_q;
  logic [SKIP_W-1:0] skip_cnt_q, skip_cnt_d;
  logic              drain_q, drain_d;

  logic              in_acc;
  logic              skipping;
  logic              shift;
  logic              full;
  logic              match;
  logic              end_done;
  logic              buf_full;
  logic              push;
  ffs_out_t          push_data;

  ffs_cell_ctl_t     ctl   [FLAG_BITS];
  logic [FLAG_BITS-1:0] valid, held_bit, sh_bit, sh_valid, head;
  logic [FLAG_BITS-1:0] prev_bit, prev_valid, above_valid;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full | drain_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign skipping    = skip_flag_q & (skip_cnt_q < SKIP_W'(FLAG_BITS));
  assign shift       = in_acc & ~skipping;
  assign full        = sh_valid[FLAG_BITS-1];
  assign match       = (sh_bit == flag_window(flag_pattern_q));
  // drain finished: window empty, end marker goes out
  assign end_done    = drain_q & ~buf_full & ~(|valid);

  // row of window cells, cell 0 holds the newest bit
  for (genvar k = 0; k < FLAG_BITS; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign prev_bit[k]   = in_data_i.bit_in;
      assign prev_valid[k] = 1'b1;
    end else begin : g_next
      assign prev_bit[k]   = held_bit[k-1];
      assign prev_valid[k] = valid[k-1];
    end
    if (k == FLAG_BITS - 1) begin : g_top
      assign above_valid[k] = 1'b0;
    end else begin : g_below
      assign above_valid[k] = valid[k+1];
    end

    always_comb begin
      ctl[k].shift = shift;
      ctl[k].pop   = drain_q & ~buf_full;
      // the oldest slot never stays occupied after a shift: it is either
      // emitted as data or dropped with a matching flag
      ctl[k].kill  = (shift & full & match) | end_done |
                     ((k == FLAG_BITS - 1) ? shift : 1'b0);
    end

    ffs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl[k]),
      .prev_bit_i   (prev_bit[k]),
      .prev_valid_i (prev_valid[k]),
      .above_valid_i(above_valid[k]),
      .valid_o      (valid[k]),
      .bit_o        (held_bit[k]),
      .sh_bit_o     (sh_bit[k]),
      .sh_valid_o   (sh_valid[k]),
      .head_o       (head[k])
    );
  end

  // result selection: window output on a transfer, else drain
  always_comb begin
    push              = 1'b0;
    push_data.kind    = KIND_DATA;
    push_data.bit_out = 1'b0;
    push_data.last    = 1'b0;
    if (in_acc) begin
      push           = shift & full;
      push_data.last = ~in_data_i.message_end;
      if (match) begin
        push_data.kind = KIND_BOUNDARY;
      end else begin
        push_data.bit_out = sh_bit[FLAG_BITS-1];
      end
    end else if (drain_q && !buf_full) begin
      push = 1'b1;
      if (|valid) begin
        push_data.bit_out = |(head & sh_bit);
      end else begin
        push_data.kind = KIND_END;
        push_data.last = 1'b1;
      end
    end
  end

  always_comb begin
    skip_cnt_d = skip_cnt_q;
    drain_d    = drain_q;
    if (in_acc && skipping) begin
      skip_cnt_d = skip_cnt_q + SKIP_W'(1);
    end
    if (in_acc && in_data_i.message_end) begin
      drain_d = 1'b1;
    end
    if (end_done) begin
      skip_cnt_d = '0;
      drain_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_pattern_q <= FLAG_PATTERN_RST;
      skip_flag_q    <= 1'b1;
      skip_cnt_q     <= '0;
      drain_q        <= 1'b0;
    end else begin
      skip_cnt_q <= skip_cnt_d;
      drain_q    <= drain_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_FLAG_PATTERN: flag_pattern_q <= cfg_data_i;
          REG_SKIP_FLAG:    skip_flag_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  ffs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/ffs_checker.sv]
// ----------------------------------------------------------------------------
// ffs_checker
// Port-level checks of the flag frame splitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input ffs_pkg::ffs_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ffs_pkg::ffs_out_t out_data_o
);
  import ffs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // the end marker is always the final result of its input
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_END |-> out_data_o.last)
    else $error("end marker without last");

  // only data results carry a bit
  a_bit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_DATA |-> !out_data_o.bit_out)
    else $error("bit set on non-data result");

  // a message end transfer starts the flush, which blocks input
  a_end_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.message_end |=> in_stall_o)
    else $error("input taken during flush");

endmodule

bind flag_frame_splitter_unit ffs_checker u_ffs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
